// ===== rtl/page_frame_replacement_fifo_lru_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PAGE_FRAME_REPLACEMENT_FIFO_LRU_CORE_DEFINES_SVH
`define PAGE_FRAME_REPLACEMENT_FIFO_LRU_CORE_DEFINES_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define PFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfr assertion failed");

// Condition in one cycle implies consequence in the next cycle.
`define PFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfr assertion failed");

`endif

// ===== rtl/pfr_pkg.sv =====
package pfr_pkg;

  localparam int MAX_FRAMES_DEF = 16;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int STAMP_W     = 32;
  localparam int FAULT_W     = 32;
  localparam int FRAME_IDX_W = 4;
  localparam int FIU_W       = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [FIU_W-1:0]   FIU_RESET = 5'd4;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY_MODE   = 1'b0,
    CFG_FRAMES_IN_USE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_e;

  // Sequencer to scan unit
  typedef struct packed {
    logic clear;
    logic eval;
  } scan_ctrl_t;

  // Scan unit to sequencer
  typedef struct packed {
    logic hit;
    logic empty;
  } scan_flags_t;

endpackage

// ===== rtl/pfr_frame_mem.sv =====
module pfr_frame_mem #(
  parameter int DEPTH     = pfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF,
  localparam int IdxW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [IdxW-1:0]              rd_addr_i,
  input  logic                         wr_page_en_i,
  input  logic                         wr_stamp_en_i,
  input  logic [IdxW-1:0]              wr_addr_i,
  input  logic [PAGE_BITS-1:0]         wr_page_i,
  input  logic [pfr_pkg::STAMP_W-1:0]  wr_stamp_i,
  output logic [PAGE_BITS-1:0]         rd_page_o,
  output logic [pfr_pkg::STAMP_W-1:0]  rd_stamp_o
);

  logic [PAGE_BITS-1:0]        page_mem [DEPTH];
  logic [pfr_pkg::STAMP_W-1:0] stamp_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_page_en_i) begin
      page_mem[wr_addr_i] <= wr_page_i;
    end
    if (wr_stamp_en_i) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_page_o  <= page_mem[rd_addr_i];
      rd_stamp_o <= stamp_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/pfr_scan_unit.sv =====
module pfr_scan_unit #(
  parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF,
  localparam int IdxW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfr_pkg::scan_ctrl_t          ctrl_i,
  input  logic [IdxW-1:0]              idx_i,
  input  logic                         valid_i,
  input  logic [PAGE_BITS-1:0]         page_i,
  input  logic [pfr_pkg::STAMP_W-1:0]  stamp_i,
  input  logic [PAGE_BITS-1:0]         req_page_i,
  input  logic [IdxW-1:0]              fifo_ptr_i,
  output pfr_pkg::scan_flags_t         flags_o,
  output logic [IdxW-1:0]              hit_idx_o,
  output logic [IdxW-1:0]              empty_idx_o,
  output logic [IdxW-1:0]              min_idx_o,
  output logic [PAGE_BITS-1:0]         min_page_o,
  output logic [PAGE_BITS-1:0]         fifo_page_o
);

  pfr_pkg::scan_flags_t         flags_q;
  logic [pfr_pkg::STAMP_W-1:0]  min_stamp_q;
  logic                         page_eq;
  logic                         stamp_lt;

  // One compare pair serves every frame in turn.
  assign page_eq  = (page_i == req_page_i);
  assign stamp_lt = (stamp_i < min_stamp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctrl_i.clear) begin
      flags_q <= '0;
    end else if (ctrl_i.eval) begin
      if (valid_i && page_eq) begin
        flags_q.hit <= 1'b1;
      end
      if (!valid_i) begin
        flags_q.empty <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.eval) begin
      // Keep the first match and the first hole only.
      if (valid_i && page_eq && !flags_q.hit) begin
        hit_idx_o <= idx_i;
      end
      if (!valid_i && !flags_q.empty) begin
        empty_idx_o <= idx_i;
      end
      // Strict less-than keeps the lowest index on equal stamps.
      if ((idx_i == '0) || stamp_lt) begin
        min_idx_o   <= idx_i;
        min_stamp_q <= stamp_i;
        min_page_o  <= page_i;
      end
      if (idx_i == fifo_ptr_i) begin
        fifo_page_o <= page_i;
      end
    end
  end

  assign flags_o = flags_q;

endmodule

// ===== rtl/page_frame_replacement_fifo_lru_core.sv =====
// Page frame replacement core, FIFO or LRU victim selection.
//
// Request channel: drive page_number_i and raise start_i; the request
// transfers at a rising edge where start_i is high and busy_o is low.
// Result channel: result_valid_o is high for exactly one cycle with hit_o,
// frame_index_o, evicted_valid_o, evicted_page_o and fault_total_o. The
// receiver cannot stall, so the result must be captured in that cycle.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i write register 0 (policy,
// 0 FIFO / 1 LRU) or register 1 (frames in use) at the clock edge; write
// only while busy_o is low and no result is pending.
// Sequence: a request walks ST_SCAN, which issues one frame memory read
// per effective frame, then ST_LAST, which evaluates the last read, then
// ST_DECIDE, which decides and updates state; the strobe follows. busy_o
// is already low in the strobe cycle, so a new request can transfer then.
// Until then the core takes no new request, since the scan walks the
// single read port of the frame memory one entry per cycle.
// Reset: all frames invalid, stamp, FIFO pointer and fault count zero,
// policy FIFO, four frames in use. No clearing pass is needed.
module page_frame_replacement_fifo_lru_core #(
  parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [PAGE_BITS-1:0]              page_number_i,
  input  logic                              cfg_we_i,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [pfr_pkg::FRAME_IDX_W-1:0]   frame_index_o,
  output logic                              evicted_valid_o,
  output logic [PAGE_BITS-1:0]              evicted_page_o,
  output logic [pfr_pkg::FAULT_W-1:0]       fault_total_o
);

  localparam int IdxW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW  = $clog2(MAX_FRAMES + 1);
  localparam int CmpW  = ((CntW > pfr_pkg::FIU_W) ? CntW : pfr_pkg::FIU_W) + 1;
  localparam int FiW   = pfr_pkg::FRAME_IDX_W;
  localparam int StW   = pfr_pkg::STAMP_W;
  localparam int FltW  = pfr_pkg::FAULT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DECIDE
  } state_e;

  state_e                     state_q;
  pfr_pkg::policy_e           policy_q;
  logic [pfr_pkg::FIU_W-1:0]  fiu_q;

  logic [MAX_FRAMES-1:0]      frame_valid_q;
  logic [StW-1:0]             stamp_q;
  logic [IdxW-1:0]            fifo_ptr_q;
  logic [FltW-1:0]            fault_q;

  logic [PAGE_BITS-1:0]       req_page_q;
  logic [CntW-1:0]            n_q;
  logic [IdxW-1:0]            ptr_q;
  logic [CntW-1:0]            addr_q;
  logic                       eval_q;
  logic [IdxW-1:0]            eval_idx_q;

  logic                       accept;
  logic [CntW-1:0]            eff_frames;
  logic [IdxW-1:0]            ptr_start;
  logic [CntW-1:0]            ptr_plus;
  logic [IdxW-1:0]            ptr_next;

  pfr_pkg::scan_ctrl_t        scan_ctrl;
  pfr_pkg::scan_flags_t       scan_flags;
  logic [IdxW-1:0]            hit_idx;
  logic [IdxW-1:0]            empty_idx;
  logic [IdxW-1:0]            min_idx;
  logic [PAGE_BITS-1:0]       min_page;
  logic [PAGE_BITS-1:0]       fifo_page;

  logic [PAGE_BITS-1:0]       rd_page;
  logic [StW-1:0]             rd_stamp;

  logic [IdxW-1:0]            slot_d;
  logic                       evicted_d;
  logic [PAGE_BITS-1:0]       old_page_d;
  logic                       decide;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign decide = (state_q == ST_DECIDE);

  // Clamp the frame count: zero acts as one, beyond capacity acts as capacity.
  always_comb begin
    if (fiu_q == '0) begin
      eff_frames = CntW'(1);
    end else if (CmpW'(fiu_q) > CmpW'(MAX_FRAMES)) begin
      eff_frames = CntW'(MAX_FRAMES);
    end else begin
      eff_frames = CntW'(fiu_q);
    end
  end

  // Wrap a stale FIFO pointer back to frame zero.
  assign ptr_start = (CntW'(fifo_ptr_q) >= eff_frames) ? '0 : fifo_ptr_q;
  assign ptr_plus  = CntW'(ptr_q) + CntW'(1);
  assign ptr_next  = (ptr_plus == n_q) ? '0 : ptr_plus[IdxW-1:0];

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pfr_pkg::POLICY_FIFO;
      fiu_q    <= pfr_pkg::FIU_RESET;
    end else if (cfg_we_i) begin
      unique case (pfr_pkg::cfg_reg_e'(cfg_idx_i))
        pfr_pkg::CFG_POLICY_MODE:   policy_q <= pfr_pkg::policy_e'(cfg_data_i[0]);
        pfr_pkg::CFG_FRAMES_IN_USE: fiu_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Victim choice: hit frame, else first hole, else the policy's pick.
  always_comb begin
    evicted_d  = 1'b0;
    old_page_d = '0;
    if (scan_flags.hit) begin
      slot_d = hit_idx;
    end else if (scan_flags.empty) begin
      slot_d = empty_idx;
    end else begin
      evicted_d = 1'b1;
      if (policy_q == pfr_pkg::POLICY_LRU) begin
        slot_d     = min_idx;
        old_page_d = min_page;
      end else begin
        slot_d     = ptr_q;
        old_page_d = fifo_page;
      end
    end
  end

  assign scan_ctrl.clear = accept;
  assign scan_ctrl.eval  = eval_q;

  pfr_frame_mem #(
    .DEPTH     (MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_mem (
    .clk_i         (clk_i),
    .rd_en_i       (state_q == ST_SCAN),
    .rd_addr_i     (addr_q[IdxW-1:0]),
    .wr_page_en_i  (decide && !scan_flags.hit),
    .wr_stamp_en_i (decide),
    .wr_addr_i     (slot_d),
    .wr_page_i     (req_page_q),
    .wr_stamp_i    (stamp_q),
    .rd_page_o     (rd_page),
    .rd_stamp_o    (rd_stamp)
  );

  pfr_scan_unit #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .idx_i       (eval_idx_q),
    .valid_i     (frame_valid_q[eval_idx_q]),
    .page_i      (rd_page),
    .stamp_i     (rd_stamp),
    .req_page_i  (req_page_q),
    .fifo_ptr_i  (ptr_q),
    .flags_o     (scan_flags),
    .hit_idx_o   (hit_idx),
    .empty_idx_o (empty_idx),
    .min_idx_o   (min_idx),
    .min_page_o  (min_page),
    .fifo_page_o (fifo_page)
  );

  // Sequencer, persistent state and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_valid_q  <= '0;
      stamp_q        <= '0;
      fifo_ptr_q     <= '0;
      fault_q        <= '0;
      addr_q         <= '0;
      eval_q         <= 1'b0;
      eval_idx_q     <= '0;
      n_q            <= '0;
      ptr_q          <= '0;
      req_page_q     <= '0;
      result_valid_o <= 1'b0;
      hit_o          <= 1'b0;
      frame_index_o  <= '0;
      evicted_valid_o <= 1'b0;
      evicted_page_o <= '0;
      fault_total_o  <= '0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            // Latch the request and bump the stamp before the scan.
            req_page_q <= page_number_i;
            stamp_q    <= stamp_q + StW'(1);
            n_q        <= eff_frames;
            ptr_q      <= ptr_start;
            addr_q     <= '0;
            eval_q     <= 1'b0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle; evaluate it in the next.
          eval_q     <= 1'b1;
          eval_idx_q <= addr_q[IdxW-1:0];
          addr_q     <= addr_q + CntW'(1);
          if ((addr_q + CntW'(1)) == n_q) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          eval_q  <= 1'b0;
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          frame_valid_q[slot_d] <= 1'b1;
          if (!scan_flags.hit) begin
            fifo_ptr_q <= ptr_next;
            if (fault_q != pfr_pkg::FAULT_MAX) begin
              fault_q       <= fault_q + FltW'(1);
              fault_total_o <= fault_q + FltW'(1);
            end else begin
              fault_total_o <= fault_q;
            end
          end else begin
            fault_total_o <= fault_q;
          end
          result_valid_o  <= 1'b1;
          hit_o           <= scan_flags.hit;
          frame_index_o   <= FiW'(slot_d);
          evicted_valid_o <= evicted_d;
          evicted_page_o  <= old_page_d;
          state_q         <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pfr_checker.sv =====
`include "page_frame_replacement_fifo_lru_core_defines.svh"

module pfr_checker #(
  parameter int PAGE_BITS = pfr_pkg::PAGE_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_i,
  input logic                 result_valid_i,
  input logic                 hit_i,
  input logic                 evicted_valid_i,
  input logic [PAGE_BITS-1:0] evicted_page_i
);

  // Result strobe lasts a single cycle.
  `PFR_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_i, !result_valid_i)

  // A transferred request keeps the core busy in the next cycle.
  `PFR_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_i, busy_i)

  // The result is shown while the core is idle again.
  `PFR_ASSERT_SAME(a_result_idle, clk_i, rst_ni, result_valid_i, !busy_i)

  // A hit never evicts and reports no evicted page.
  `PFR_ASSERT_SAME(a_hit_no_evict, clk_i, rst_ni, result_valid_i && hit_i, !evicted_valid_i && (evicted_page_i == '0))

endmodule

bind page_frame_replacement_fifo_lru_core pfr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_pfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_i          (busy_o),
  .result_valid_i  (result_valid_o),
  .hit_i           (hit_o),
  .evicted_valid_i (evicted_valid_o),
  .evicted_page_i  (evicted_page_o)
);

// ===== tb/sv/page_frame_replacement_fifo_lru_core_tb.sv =====
module page_frame_replacement_fifo_lru_core_tb;
  import pfr_pkg::*;

  localparam int MAX_FRAMES = MAX_FRAMES_DEF;
  localparam int PAGE_BITS  = PAGE_BITS_DEF;

  // Stop queueing random phases once this many page requests are queued.
  localparam int unsigned RANDOM_ITEMS = 1100;
  // Allow twice the worst request, at MAX_FRAMES frames, to drain.
  localparam int unsigned DRAIN_CYCLES = 2 * (MAX_FRAMES + 3);
  // Slowest run is about 1300 transfers; this time limit is far above it.
  localparam longint unsigned RUN_LIMIT = 64'd3_200_000;

  typedef enum logic { XFER_PAGE, XFER_CFG } xfer_kind_e;

  // One entry of the driver's queue: a page request or a register write.
  typedef struct {
    xfer_kind_e           kind;
    logic [PAGE_BITS-1:0] page;
    cfg_reg_e             idx;
    logic [CFG_DATA_W-1:0] data;
    int unsigned          gap;
  } xfer_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame;
    logic                   ev_valid;
    logic [PAGE_BITS-1:0]   ev_page;
    logic [FAULT_W-1:0]     faults;
  } page_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [PAGE_BITS-1:0] page_number_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic busy_o;
  logic result_valid_o;
  logic hit_o;
  logic [FRAME_IDX_W-1:0] frame_index_o;
  logic evicted_valid_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic [FAULT_W-1:0] fault_total_o;

  page_frame_replacement_fifo_lru_core #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .page_number_i  (page_number_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .frame_index_o  (frame_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Page table shadow: the testbench's own copy of the frame store, the
  // stamps, the FIFO pointer, the fault counter and both registers.
  // ---------------------------------------------------------------------
  policy_e              policy_shadow = POLICY_FIFO;
  logic [FIU_W-1:0]     frames_shadow = FIU_RESET;
  logic [PAGE_BITS-1:0] frame_page_sh [MAX_FRAMES];
  bit                   frame_valid_sh [MAX_FRAMES];
  logic [STAMP_W-1:0]   frame_stamp_sh [MAX_FRAMES];
  logic [STAMP_W-1:0]   req_stamp_sh = '0;
  int unsigned          fifo_ptr_sh = 0;
  logic [FAULT_W-1:0]   fault_cnt_sh = '0;

  page_result_t predicted_results[$];
  xfer_t        xfer_queue[$];
  xfer_t        cur_xfer;
  bit           have_cur = 1'b0;
  bit           no_idle = 1'b0;
  int unsigned  gap_left = 0;
  int unsigned  sent_count = 0;
  int unsigned  took_count = 0;
  int unsigned  page_total = 0;
  int           fail_count = 0;

  initial begin
    for (int i = 0; i < MAX_FRAMES; i++) frame_valid_sh[i] = 1'b0;
  end

  // Clamp the frame count the way the block does: 0 acts as 1, anything
  // above the store size acts as the store size.
  function automatic int unsigned active_frames(input logic [FIU_W-1:0] fiu);
    if (fiu == 0) return 1;
    if (fiu > MAX_FRAMES) return MAX_FRAMES;
    return fiu;
  endfunction

  // Resolve one page request against the shadow and advance its state.
  function automatic page_result_t resolve_page(input logic [PAGE_BITS-1:0] pg);
    page_result_t res;
    int unsigned  n;
    int unsigned  slot;
    int unsigned  ptr;
    bit           found;
    bit           empty;
    res = '0;
    n = active_frames(frames_shadow);
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    req_stamp_sh = req_stamp_sh + 1'b1;
    // Lowest searched frame holding the page wins; frames at or above n
    // are left alone even if they hold the same page.
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && frame_valid_sh[i] && frame_page_sh[i] == pg) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      frame_stamp_sh[slot] = req_stamp_sh;
    end else begin
      // A stale pointer from a larger frame count falls back to frame 0.
      ptr = (fifo_ptr_sh >= n) ? 0 : fifo_ptr_sh;
      if (fault_cnt_sh != FAULT_MAX) fault_cnt_sh = fault_cnt_sh + 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
        if (!empty && !frame_valid_sh[i]) begin
          slot = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        if (policy_shadow == POLICY_FIFO) begin
          slot = ptr;
        end else begin
          // Oldest raw stamp, lowest index on ties.
          slot = 0;
          for (int unsigned i = 1; i < n; i++) begin
            if (frame_stamp_sh[i] < frame_stamp_sh[slot]) slot = i;
          end
        end
        res.ev_valid = 1'b1;
        res.ev_page = frame_page_sh[slot];
      end
      frame_page_sh[slot] = pg;
      frame_valid_sh[slot] = 1'b1;
      frame_stamp_sh[slot] = req_stamp_sh;
      fifo_ptr_sh = (ptr + 1) % n;
    end
    res.hit = found;
    res.frame = FRAME_IDX_W'(slot);
    res.faults = fault_cnt_sh;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_page(input logic [PAGE_BITS-1:0] pg);
    xfer_t x;
    x.kind = XFER_PAGE;
    x.page = pg;
    x.idx = CFG_POLICY_MODE;
    x.data = '0;
    x.gap = no_idle ? 0 : $urandom_range(0, 8);
    xfer_queue.push_back(x);
    page_total++;
  endtask

  task automatic queue_cfg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    xfer_t x;
    x.kind = XFER_CFG;
    x.page = '0;
    x.idx = idx;
    x.data = data;
    x.gap = no_idle ? 0 : $urandom_range(0, 8);
    xfer_queue.push_back(x);
  endtask

  // Policy writes carry random upper bits; only bit 0 selects the policy.
  function automatic logic [CFG_DATA_W-1:0] policy_word(input policy_e pol);
    return CFG_DATA_W'($urandom_range(0, 15) << 1) | CFG_DATA_W'(pol);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: change inputs at the falling edge only. A request holds
  // start_i until the monitor has counted its transfer; a register write
  // waits until the block is idle and every result is in.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin : drv
    logic nxt_start;
    logic nxt_we;
    if (rst_ni) begin
      nxt_start = start_i;
      nxt_we = 1'b0;
      // Drop start_i once the pending request has transferred, unless the
      // next one follows back to back below.
      if (start_i && took_count == sent_count) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (!have_cur && xfer_queue.size() != 0) begin
          cur_xfer = xfer_queue.pop_front();
          have_cur = 1'b1;
          gap_left = cur_xfer.gap;
        end
        if (have_cur) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (cur_xfer.kind == XFER_PAGE) begin
            nxt_start = 1'b1;
            page_number_i <= cur_xfer.page;
            sent_count++;
            have_cur = 1'b0;
          end else if (predicted_results.size() == 0 && took_count == sent_count) begin
            nxt_we = 1'b1;
            cfg_idx_i <= cur_xfer.idx;
            cfg_data_i <= cur_xfer.data;
            have_cur = 1'b0;
          end
        end
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: sample at the rising edge. Check a strobed result against the
  // oldest prediction first, then apply a register write, then predict a
  // request that transfers on this edge.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    page_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (predicted_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          fail_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit_o));
          check_field("frame_index", 32'(want.frame), 32'(frame_index_o));
          check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid_o));
          check_field("evicted_page", 32'(want.ev_page), 32'(evicted_page_o));
          check_field("fault_total", 32'(want.faults), 32'(fault_total_o));
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_POLICY_MODE: begin
            policy_shadow = policy_e'(cfg_data_i[0]);
          end
          CFG_FRAMES_IN_USE: begin
            frames_shadow = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (start_i && !busy_o) begin
        predicted_results.push_back(resolve_page(page_number_i));
        took_count++;
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    logic [PAGE_BITS-1:0] ws[$];
    logic [PAGE_BITS-1:0] pg;
    logic [CFG_DATA_W-1:0] fr;
    policy_e              pol;
    int unsigned          n_eff;
    int unsigned          len;
    int unsigned          sel;

    // Directed part, starting from the reset setting: FIFO, four frames.
    // Fill in order, hit, then evict under the wrapped pointer.
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h0000);
    queue_page(16'h5555);
    queue_page(16'hAAAA);
    queue_page(16'h1234);
    queue_page(16'hFFFF);
    // LRU on the same contents: evict the oldest stamp, then refresh one.
    queue_cfg(CFG_POLICY_MODE, policy_word(POLICY_LRU));
    queue_page(16'h00FF);
    queue_page(16'hAAAA);
    // Zero frames acts as one: the page still sitting in frame 3 is not
    // searched, so it misses and lands in frame 0 as a duplicate.
    queue_cfg(CFG_FRAMES_IN_USE, 5'd0);
    queue_page(16'hAAAA);
    // Grow back: both copies are searched and the lower frame wins.
    queue_cfg(CFG_FRAMES_IN_USE, 5'd4);
    queue_page(16'hAAAA);
    // Walk the FIFO pointer up to 3, then shrink so it falls back to 0.
    queue_cfg(CFG_POLICY_MODE, policy_word(POLICY_FIFO));
    queue_page(16'h0F0F);
    queue_page(16'hF0F0);
    queue_page(16'h3C3C);
    queue_cfg(CFG_FRAMES_IN_USE, 5'd2);
    queue_page(16'h7777);
    // Oversized counts clamp to the full store; kept frames count again.
    queue_cfg(CFG_FRAMES_IN_USE, 5'd31);
    queue_page(16'h8000);
    queue_page(16'h0001);
    queue_page(16'h8001);
    queue_cfg(CFG_FRAMES_IN_USE, 5'd17);
    queue_page(16'hAAAA);
    queue_page(16'h8000);
    queue_cfg(CFG_POLICY_MODE, policy_word(POLICY_LRU));
    queue_cfg(CFG_FRAMES_IN_USE, 5'd1);
    queue_page(16'h4242);
    queue_page(16'h4242);

    // Random phases: each picks a policy and a frame count, then works a
    // small set of pages so hits, fills and evictions all happen; a share
    // of requests drifts the set or is pure noise across all 16 bits.
    page_total = 0;
    while (page_total < RANDOM_ITEMS) begin
      pol = policy_e'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: fr = 5'd1;
        1: fr = 5'(MAX_FRAMES);
        2: fr = 5'd0;
        3: fr = 5'($urandom_range(MAX_FRAMES + 1, 31));
        default: fr = 5'($urandom_range(1, MAX_FRAMES));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      queue_cfg(CFG_POLICY_MODE, policy_word(pol));
      queue_cfg(CFG_FRAMES_IN_USE, fr);
      n_eff = active_frames(fr);
      ws.delete();
      for (int unsigned k = 0; k < n_eff + $urandom_range(0, 4); k++) begin
        ws.push_back(PAGE_BITS'($urandom));
      end
      len = $urandom_range(30, 90);
      for (int unsigned k = 0; k < len; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          pg = ws[$urandom_range(0, ws.size() - 1)];
        end else if (sel < 90) begin
          pg = PAGE_BITS'($urandom);
          ws[$urandom_range(0, ws.size() - 1)] = pg;
        end else begin
          pg = PAGE_BITS'($urandom);
        end
        queue_page(pg);
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Hold until every transfer has gone out and every result is in.
    while (xfer_queue.size() != 0 || have_cur || took_count != sent_count ||
           predicted_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
